// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define CHK_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("check failed");

`endif

// ===== design/cri_pkg.sv =====
// ----------------------------------------------------------------------------
// cri_pkg
// Shared constants, codes and control types of the waypoint interpolator.
// ----------------------------------------------------------------------------
package cri_pkg;

  localparam int MAX_WP    = 64;
  localparam int FRAC_BITS = 16;
  localparam int AW        = $clog2(MAX_WP);
  localparam int CNT_W     = $clog2(MAX_WP + 1);
  localparam int POS_W     = 32;
  localparam int LOOK_W    = 18;
  localparam int T_W       = 22;
  localparam int INT_W     = T_W - FRAC_BITS;
  localparam int PT_W      = POS_W + 1;
  localparam int WT_W      = FRAC_BITS + 7;
  localparam int PROD_W    = PT_W + WT_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int SH_W      = ACC_W - FRAC_BITS - 1;
  localparam int ENT_W     = 3 * POS_W + 3 * LOOK_W;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_EVAL   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_SAT   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_EDGE_RD,
    S_EDGE_CAP,
    S_SQ,
    S_CU,
    S_WGT,
    S_RD,
    S_DRAIN1,
    S_DRAIN2,
    S_DONE
  } state_t;

  // read order of the segment's control points
  typedef enum logic [2:0] {
    RSEL_P1   = 3'd0,
    RSEL_P2   = 3'd1,
    RSEL_P0   = 3'd2,
    RSEL_P3   = 3'd3,
    RSEL_EDGE = 3'd4
  } rsel_t;

  typedef struct packed {
    logic  latch;
    logic  wr_go;
    logic  rd_en;
    rsel_t rd_sel;
    logic  sq_go;
    logic  cu_go;
    logic  wgt_go;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  empty;
    logic  at_end;
  } sts_t;

endpackage

// ===== design/catmull_rom_waypoint_interpolator.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_waypoint_interpolator
// Catmull-Rom (tension 0.5) interpolation through a table of 3D waypoints.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat is an append, a clear, an
// unused mode or an evaluation at in_param_t. Output channel
// (out_valid/out_ready): exactly one result beat per input beat, in order.
// One item at a time. From the accepting edge to out_valid: dispatch and
// output load for append, clear, unused mode and an empty-table evaluation;
// dispatch, store read, capture and output load for an evaluation at an end
// point; for an interior evaluation dispatch, the basis steps (square, cube,
// weights), four reads of the single-port waypoint store (one control point
// each), two drain steps for multiply and accumulate, and the output load.
// in_ready rises again in the cycle after the output load.
// in_ready is high only while the block is idle. A finished result sits in
// the output register; the next item is accepted meanwhile, and its result
// waits in the datapath until the receiver takes the earlier one.
// Reset empties the table (count zero) and drops any pending result; the
// store itself is not cleared.
// ----------------------------------------------------------------------------
module catmull_rom_waypoint_interpolator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic signed [cri_pkg::POS_W-1:0]  in_pos_x,
  input  logic signed [cri_pkg::POS_W-1:0]  in_pos_y,
  input  logic signed [cri_pkg::POS_W-1:0]  in_pos_z,
  input  logic signed [cri_pkg::LOOK_W-1:0] in_look_x,
  input  logic signed [cri_pkg::LOOK_W-1:0] in_look_y,
  input  logic signed [cri_pkg::LOOK_W-1:0] in_look_z,
  input  logic [cri_pkg::T_W-1:0]           in_param_t,
  input  logic                              in_want_tangent,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cri_pkg::POS_W-1:0]  out_x,
  output logic signed [cri_pkg::POS_W-1:0]  out_y,
  output logic signed [cri_pkg::POS_W-1:0]  out_z,
  output logic [1:0]                        out_status,
  output logic [cri_pkg::CNT_W-1:0]         out_waypoint_count
);

  cri_pkg::cmd_t cmd;
  cri_pkg::sts_t sts;

  cri_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cri_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_mode),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_look_x          (in_look_x),
    .in_look_y          (in_look_y),
    .in_look_z          (in_look_z),
    .in_param_t         (in_param_t),
    .in_want_tangent    (in_want_tangent),
    .cmd                (cmd),
    .sts                (sts),
    .out_x              (out_x),
    .out_y              (out_y),
    .out_z              (out_z),
    .out_status         (out_status),
    .out_waypoint_count (out_waypoint_count)
  );

endmodule

// ===== design/cri_ram.sv =====
// ----------------------------------------------------------------------------
// cri_ram
// Single-port RAM, write or registered read each cycle.
// ----------------------------------------------------------------------------
module cri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/cri_ctrl.sv =====
// ----------------------------------------------------------------------------
// cri_ctrl
// Sequencer: dispatches each item and steps the datapath through it.
// ----------------------------------------------------------------------------
module cri_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  cri_pkg::sts_t sts,
  output cri_pkg::cmd_t cmd
);

  cri_pkg::state_t state_r, state_nxt;
  logic [1:0]      k_r, k_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cri_pkg::S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    cmd.rd_sel    = cri_pkg::RSEL_P1;
    in_ready      = 1'b0;
    case (state_r)
      cri_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = cri_pkg::S_DISP;
        end
      end
      cri_pkg::S_DISP: begin
        if (sts.mode != cri_pkg::MODE_EVAL) begin
          cmd.wr_go = 1'b1;
          state_nxt = cri_pkg::S_DONE;
        end else if (sts.empty) begin
          state_nxt = cri_pkg::S_DONE;
        end else if (sts.at_end) begin
          state_nxt = cri_pkg::S_EDGE_RD;
        end else begin
          state_nxt = cri_pkg::S_SQ;
        end
      end
      cri_pkg::S_EDGE_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = cri_pkg::RSEL_EDGE;
        state_nxt  = cri_pkg::S_EDGE_CAP;
      end
      cri_pkg::S_EDGE_CAP: begin
        state_nxt = cri_pkg::S_DONE;
      end
      cri_pkg::S_SQ: begin
        cmd.sq_go = 1'b1;
        state_nxt = cri_pkg::S_CU;
      end
      cri_pkg::S_CU: begin
        cmd.cu_go = 1'b1;
        state_nxt = cri_pkg::S_WGT;
      end
      cri_pkg::S_WGT: begin
        cmd.wgt_go = 1'b1;
        k_nxt      = '0;
        state_nxt  = cri_pkg::S_RD;
      end
      cri_pkg::S_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = cri_pkg::rsel_t'({1'b0, k_r});
        k_nxt      = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = cri_pkg::S_DRAIN1;
        end
      end
      cri_pkg::S_DRAIN1: begin
        state_nxt = cri_pkg::S_DRAIN2;
      end
      cri_pkg::S_DRAIN2: begin
        state_nxt = cri_pkg::S_DONE;
      end
      cri_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = cri_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cri_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/cri_dp.sv =====
// ----------------------------------------------------------------------------
// cri_dp
// Datapath: waypoint store, basis weights, multiply-accumulate, result regs.
// ----------------------------------------------------------------------------
module cri_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [1:0]                          in_mode,
  input  logic signed [cri_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [cri_pkg::POS_W-1:0]    in_pos_y,
  input  logic signed [cri_pkg::POS_W-1:0]    in_pos_z,
  input  logic signed [cri_pkg::LOOK_W-1:0]   in_look_x,
  input  logic signed [cri_pkg::LOOK_W-1:0]   in_look_y,
  input  logic signed [cri_pkg::LOOK_W-1:0]   in_look_z,
  input  logic [cri_pkg::T_W-1:0]             in_param_t,
  input  logic                                in_want_tangent,
  input  cri_pkg::cmd_t                       cmd,
  output cri_pkg::sts_t                       sts,
  output logic signed [cri_pkg::POS_W-1:0]    out_x,
  output logic signed [cri_pkg::POS_W-1:0]    out_y,
  output logic signed [cri_pkg::POS_W-1:0]    out_z,
  output logic [1:0]                          out_status,
  output logic [cri_pkg::CNT_W-1:0]           out_waypoint_count
);

  localparam logic [2*cri_pkg::FRAC_BITS:0] HALF = (2*cri_pkg::FRAC_BITS+1)'(1)
                                                   << (cri_pkg::FRAC_BITS - 1);
  localparam logic [cri_pkg::WT_W-1:0] ONE = cri_pkg::WT_W'(1) << cri_pkg::FRAC_BITS;
  localparam logic [cri_pkg::ACC_W-1:0] RND = cri_pkg::ACC_W'(1) << cri_pkg::FRAC_BITS;

  // latched item, waypoint count and full flag
  cri_pkg::mode_t                     mode_r;
  logic [cri_pkg::ENT_W-1:0]          ent_r;
  logic [cri_pkg::T_W-1:0]            t_r;
  logic                               tan_r;
  logic [cri_pkg::CNT_W-1:0]          count_r;
  logic                               full_r;

  logic [cri_pkg::FRAC_BITS-1:0]      f;
  logic [cri_pkg::INT_W-1:0]          seg;

  // basis
  logic [2*cri_pkg::FRAC_BITS-1:0]    ff_r;
  logic [cri_pkg::FRAC_BITS:0]        sq_r;
  logic [2*cri_pkg::FRAC_BITS:0]      cp_r;
  logic [2*cri_pkg::FRAC_BITS:0]      sq_sum;
  logic [2*cri_pkg::FRAC_BITS+1:0]    cu_sum;
  logic [cri_pkg::FRAC_BITS:0]        sq_c;
  logic [cri_pkg::FRAC_BITS:0]        cu_c;
  logic signed [cri_pkg::WT_W-1:0]    u0, u1, u2, u3;
  logic signed [cri_pkg::WT_W-1:0]    w0_r, w1_r, w2_r, w3_r;

  // store
  logic                               ram_we;
  logic [cri_pkg::AW-1:0]             ram_addr, rd_addr;
  logic [cri_pkg::ENT_W-1:0]          ram_rdata;
  logic                               rd_vld_r;
  cri_pkg::rsel_t                     rd_sel_r;

  logic signed [cri_pkg::POS_W-1:0]   rpos  [3];
  logic signed [cri_pkg::LOOK_W-1:0]  rlook [3];
  logic signed [cri_pkg::POS_W-1:0]   e1_pos [3], e2_pos [3], edge_pos [3];
  logic signed [cri_pkg::LOOK_W-1:0]  e1_look [3], e2_look [3];

  // MAC
  logic signed [cri_pkg::PT_W-1:0]    pt [3];
  logic signed [cri_pkg::WT_W-1:0]    wsel;
  logic signed [cri_pkg::PROD_W-1:0]  prod_r [3];
  logic                               prod_vld_r;
  logic signed [cri_pkg::ACC_W-1:0]   acc_r [3];
  logic signed [cri_pkg::ACC_W-1:0]   rsum [3];
  logic signed [cri_pkg::SH_W-1:0]    rsh [3];
  logic [cri_pkg::POS_W-1:0]          rres [3];
  logic [2:0]                         rovf;

  logic signed [cri_pkg::POS_W-1:0]   ox_r, oy_r, oz_r;
  logic [1:0]                         ostat_r;
  logic [cri_pkg::CNT_W-1:0]          ocnt_r;

  assign f   = t_r[cri_pkg::FRAC_BITS-1:0];
  assign seg = t_r[cri_pkg::T_W-1:cri_pkg::FRAC_BITS];

  assign sts.mode   = mode_r;
  assign sts.empty  = (count_r == '0);
  assign sts.at_end = (t_r == '0) ||
                      (cri_pkg::CNT_W'(seg) >= count_r - cri_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= cri_pkg::mode_t'(in_mode);
      ent_r  <= {in_pos_x, in_pos_y, in_pos_z, in_look_x, in_look_y, in_look_z};
      t_r    <= in_param_t;
      tan_r  <= in_want_tangent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.wr_go) begin
      if (mode_r == cri_pkg::MODE_CLEAR) begin
        count_r <= '0;
      end else if (ram_we) begin
        count_r <= count_r + cri_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_go) begin
      full_r <= (mode_r == cri_pkg::MODE_APPEND) &&
                (count_r >= cri_pkg::CNT_W'(cri_pkg::MAX_WP));
    end
  end

  // basis weights
  assign sq_sum = {1'b0, ff_r} + HALF;
  assign sq_c   = sq_sum[2*cri_pkg::FRAC_BITS:cri_pkg::FRAC_BITS];
  assign cu_sum = {1'b0, cp_r} + {1'b0, HALF};
  assign cu_c   = cu_sum[2*cri_pkg::FRAC_BITS:cri_pkg::FRAC_BITS];

  always_ff @(posedge clk) begin
    if (cmd.sq_go) begin
      ff_r <= f * f;
    end
    if (cmd.cu_go) begin
      sq_r <= sq_c;
      cp_r <= sq_c * {1'b0, f};
    end
  end

  always_comb begin
    if (tan_r) begin
      u0 = '0;
      u1 = ONE;
      u2 = cri_pkg::WT_W'(f) <<< 1;
      u3 = (cri_pkg::WT_W'(sq_r) <<< 1) + cri_pkg::WT_W'(sq_r);
    end else begin
      u0 = ONE;
      u1 = cri_pkg::WT_W'(f);
      u2 = cri_pkg::WT_W'(sq_r);
      u3 = cri_pkg::WT_W'(cu_c);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wgt_go) begin
      w0_r <= (u2 <<< 1) - u1 - u3;
      w1_r <= (u0 <<< 1) - (u2 <<< 2) - u2 + (u3 <<< 1) + u3;
      w2_r <= u1 + (u2 <<< 2) - (u3 <<< 1) - u3;
      w3_r <= u3 - u2;
    end
  end

  // waypoint store
  always_comb begin
    case (cmd.rd_sel)
      cri_pkg::RSEL_P1:   rd_addr = cri_pkg::AW'(seg);
      cri_pkg::RSEL_P2:   rd_addr = cri_pkg::AW'(seg) + cri_pkg::AW'(1);
      cri_pkg::RSEL_P0:   rd_addr = cri_pkg::AW'(seg) - cri_pkg::AW'(1);
      cri_pkg::RSEL_P3:   rd_addr = cri_pkg::AW'(seg) + cri_pkg::AW'(2);
      cri_pkg::RSEL_EDGE: rd_addr = (t_r == '0) ? '0 :
                                    cri_pkg::AW'(count_r - cri_pkg::CNT_W'(1));
      default:            rd_addr = '0;
    endcase
  end

  assign ram_we   = cmd.wr_go && (mode_r == cri_pkg::MODE_APPEND) &&
                    (count_r < cri_pkg::CNT_W'(cri_pkg::MAX_WP));
  assign ram_addr = ram_we ? count_r[cri_pkg::AW-1:0] : rd_addr;

  cri_ram #(
    .WIDTH (cri_pkg::ENT_W),
    .DEPTH (cri_pkg::MAX_WP)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ent_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.rd_en;
      prod_vld_r <= rd_vld_r && (rd_sel_r != cri_pkg::RSEL_EDGE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_sel_r <= cmd.rd_sel;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rpos[c]  = ram_rdata[cri_pkg::ENT_W-1-c*cri_pkg::POS_W -: cri_pkg::POS_W];
      rlook[c] = ram_rdata[3*cri_pkg::LOOK_W-1-c*cri_pkg::LOOK_W -: cri_pkg::LOOK_W];
    end
  end

  // control point for the beat coming back from the store
  always_comb begin
    wsel = w1_r;
    for (int c = 0; c < 3; c++) begin
      pt[c] = cri_pkg::PT_W'(rpos[c]);
    end
    case (rd_sel_r)
      cri_pkg::RSEL_P1: wsel = w1_r;
      cri_pkg::RSEL_P2: wsel = w2_r;
      cri_pkg::RSEL_P0: begin
        wsel = w0_r;
        if (seg == '0) begin
          for (int c = 0; c < 3; c++) begin
            pt[c] = cri_pkg::PT_W'(e1_pos[c]) - cri_pkg::PT_W'(e1_look[c]);
          end
        end
      end
      cri_pkg::RSEL_P3: begin
        wsel = w3_r;
        if (cri_pkg::CNT_W'(seg) + cri_pkg::CNT_W'(2) >= count_r) begin
          for (int c = 0; c < 3; c++) begin
            pt[c] = cri_pkg::PT_W'(e2_pos[c]) + cri_pkg::PT_W'(e2_look[c]);
          end
        end
      end
      default: wsel = w1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= pt[c] * wsel;
        if (rd_sel_r == cri_pkg::RSEL_P1) begin
          e1_pos[c]  <= rpos[c];
          e1_look[c] <= rlook[c];
        end
        if (rd_sel_r == cri_pkg::RSEL_P2) begin
          e2_pos[c]  <= rpos[c];
          e2_look[c] <= rlook[c];
        end
        if (rd_sel_r == cri_pkg::RSEL_EDGE) begin
          edge_pos[c] <= rpos[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.wgt_go) begin
        acc_r[c] <= '0;
      end else if (prod_vld_r) begin
        acc_r[c] <= acc_r[c] + cri_pkg::ACC_W'(prod_r[c]);
      end
    end
  end

  // round half up, scale by one half, saturate
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rsum[c] = acc_r[c] + RND;
      rsh[c]  = cri_pkg::SH_W'(rsum[c] >>> (cri_pkg::FRAC_BITS + 1));
      rovf[c] = !((&rsh[c][cri_pkg::SH_W-1:cri_pkg::POS_W-1]) ||
                  (~|rsh[c][cri_pkg::SH_W-1:cri_pkg::POS_W-1]));
      if (rovf[c]) begin
        rres[c] = rsh[c][cri_pkg::SH_W-1] ? {1'b1, {(cri_pkg::POS_W-1){1'b0}}}
                                          : {1'b0, {(cri_pkg::POS_W-1){1'b1}}};
      end else begin
        rres[c] = rsh[c][cri_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ocnt_r  <= count_r;
      ox_r    <= '0;
      oy_r    <= '0;
      oz_r    <= '0;
      ostat_r <= cri_pkg::STAT_OK;
      case (mode_r)
        cri_pkg::MODE_APPEND: begin
          if (full_r) begin
            ostat_r <= cri_pkg::STAT_FULL;
          end
        end
        cri_pkg::MODE_EVAL: begin
          if (count_r == '0) begin
            ostat_r <= cri_pkg::STAT_EMPTY;
          end else if (sts.at_end) begin
            ox_r <= edge_pos[0];
            oy_r <= edge_pos[1];
            oz_r <= edge_pos[2];
          end else begin
            ox_r <= rres[0];
            oy_r <= rres[1];
            oz_r <= rres[2];
            if (|rovf) begin
              ostat_r <= cri_pkg::STAT_SAT;
            end
          end
        end
        default: ostat_r <= cri_pkg::STAT_OK;
      endcase
    end
  end

  assign out_x              = ox_r;
  assign out_y              = oy_r;
  assign out_z              = oz_r;
  assign out_status         = ostat_r;
  assign out_waypoint_count = ocnt_r;

endmodule

// ===== design/cri_chk.sv =====
// ----------------------------------------------------------------------------
// cri_chk
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cri_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [cri_pkg::POS_W-1:0]  out_x,
  input logic [1:0]                        out_status,
  input logic [cri_pkg::CNT_W-1:0]         out_waypoint_count
);

  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CHK_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_x) && $stable(out_status))
  `CHK_NOW(a_cnt_range, out_valid, out_waypoint_count <= cri_pkg::MAX_WP)
  `CHK_NOW(a_full_cnt, out_valid && out_status == cri_pkg::STAT_FULL, out_waypoint_count == cri_pkg::MAX_WP)
  `CHK_NOW(a_empty_cnt, out_valid && out_status == cri_pkg::STAT_EMPTY, out_waypoint_count == 0 && out_x == 0)

endmodule

bind catmull_rom_waypoint_interpolator cri_chk u_cri_chk (.*);

// ===== verif/tb_catmull_rom_waypoint_interpolator.sv =====
// ----------------------------------------------------------------------------
// tb_catmull_rom_waypoint_interpolator
// Drives appends, clears, unused-mode beats and spline evaluations through the
// valid/ready input and checks every result beat against an in-bench spline predictor.
// ----------------------------------------------------------------------------
module tb_catmull_rom_waypoint_interpolator;
  timeunit 1ns;
  timeprecision 1ps;
  import cri_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] x, y, z;
    status_t                 st;
    logic [CNT_W-1:0]        cnt;
  } spline_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = MODE_CLEAR;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [LOOK_W-1:0] in_look_x = '0, in_look_y = '0, in_look_z = '0;
  logic [T_W-1:0] in_param_t = '0;
  logic in_want_tangent = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POS_W-1:0] out_x, out_y, out_z;
  logic [1:0] out_status;
  logic [CNT_W-1:0] out_waypoint_count;

  catmull_rom_waypoint_interpolator dut (.*);

  always #2 clk = ~clk;

  // predictor state
  longint wp_px[MAX_WP], wp_py[MAX_WP], wp_pz[MAX_WP];
  longint wp_lx[MAX_WP], wp_ly[MAX_WP], wp_lz[MAX_WP];
  int unsigned wp_count = 0;
  spline_res_t pending_q[$];
  int mismatches = 0;
  longint cycles = 0;
  bit hold_rx = 0;
  bit rx_hold_req = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint blend4(longint p[4], longint w[4]);
    longint acc;
    acc = p[0]*w[0] + p[1]*w[1] + p[2]*w[2] + p[3]*w[3];
    return floor_shift(acc + (64'sd1 << FRAC_BITS), FRAC_BITS + 1);
  endfunction

  function automatic spline_res_t predict_spline(mode_t m, longint px, longint py,
      longint pz, longint lx, longint ly, longint lz, int unsigned t, bit tan);
    spline_res_t r;
    longint f, sq, cu, u0, u1, u2, u3, one;
    longint w[4], ax[4], ay[4], az[4];
    int unsigned i;
    bit sat;
    r.x = 0; r.y = 0; r.z = 0; r.st = STAT_OK;
    sat = 0;
    case (m)
      MODE_APPEND: begin
        if (wp_count < MAX_WP) begin
          wp_px[wp_count] = px; wp_py[wp_count] = py; wp_pz[wp_count] = pz;
          wp_lx[wp_count] = lx; wp_ly[wp_count] = ly; wp_lz[wp_count] = lz;
          wp_count++;
        end else r.st = STAT_FULL;
      end
      MODE_CLEAR: wp_count = 0;
      MODE_EVAL: begin
        if (wp_count == 0) r.st = STAT_EMPTY;
        else if (t == 0) begin
          r.x = wp_px[0]; r.y = wp_py[0]; r.z = wp_pz[0];
        end else if (t >= ((wp_count - 1) << FRAC_BITS)) begin
          r.x = wp_px[wp_count-1]; r.y = wp_py[wp_count-1]; r.z = wp_pz[wp_count-1];
        end else begin
          i = t >> FRAC_BITS;
          one = 64'sd1 << FRAC_BITS;
          f = t & (one - 1);
          sq = (f*f + (one >> 1)) >> FRAC_BITS;
          cu = (sq*f + (one >> 1)) >> FRAC_BITS;
          if (tan) begin
            u0 = 0; u1 = one; u2 = 2*f; u3 = 3*sq;
          end else begin
            u0 = one; u1 = f; u2 = sq; u3 = cu;
          end
          w[0] = -u1 + 2*u2 - u3;
          w[1] = 2*u0 - 5*u2 + 3*u3;
          w[2] = u1 + 4*u2 - 3*u3;
          w[3] = -u2 + u3;
          if (i != 0) begin
            ax[0] = wp_px[i-1]; ay[0] = wp_py[i-1]; az[0] = wp_pz[i-1];
          end else begin
            ax[0] = wp_px[i] - wp_lx[i]; ay[0] = wp_py[i] - wp_ly[i];
            az[0] = wp_pz[i] - wp_lz[i];
          end
          ax[1] = wp_px[i]; ay[1] = wp_py[i]; az[1] = wp_pz[i];
          ax[2] = wp_px[i+1]; ay[2] = wp_py[i+1]; az[2] = wp_pz[i+1];
          if (i + 2 < wp_count) begin
            ax[3] = wp_px[i+2]; ay[3] = wp_py[i+2]; az[3] = wp_pz[i+2];
          end else begin
            ax[3] = wp_px[i+1] + wp_lx[i+1]; ay[3] = wp_py[i+1] + wp_ly[i+1];
            az[3] = wp_pz[i+1] + wp_lz[i+1];
          end
          r.x = clamp32(blend4(ax, w), sat);
          r.y = clamp32(blend4(ay, w), sat);
          r.z = clamp32(blend4(az, w), sat);
          if (sat) r.st = STAT_SAT;
        end
      end
      default: ;
    endcase
    r.cnt = wp_count;
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_beat(mode_t m, logic signed [POS_W-1:0] px, py, pz,
      logic signed [LOOK_W-1:0] lx, ly, lz, logic [T_W-1:0] t, bit tan, bit gap = 1);
    // valid drops at the accepting edge; raise it again at a later edge
    @(posedge clk);
    if (gap) idle_gap();
    in_valid <= 1'b1; in_mode <= m;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_look_x <= lx; in_look_y <= ly; in_look_z <= lz;
    in_param_t <= t; in_want_tangent <= tan;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(predict_spline(m, px, py, pz, lx, ly, lz, t, tan));
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [POS_W-1:0] rnd_pos();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
    endcase
  endfunction

  function automatic logic signed [LOOK_W-1:0] rnd_look();
    case ($urandom_range(0, 4))
      0: return 18'sh1FFFF;
      1: return 18'sh20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_append();
    send_beat(MODE_APPEND, rnd_pos(), rnd_pos(), rnd_pos(),
              rnd_look(), rnd_look(), rnd_look(), $urandom, $urandom);
  endtask

  task automatic send_eval(logic [T_W-1:0] t, bit tan);
    send_beat(MODE_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, t, tan);
  endtask

  function automatic logic [T_W-1:0] rnd_t();
    int unsigned span;
    span = (wp_count > 1) ? (wp_count - 1) << FRAC_BITS : 2 << FRAC_BITS;
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom;
      2: return span;
      3: return span - 1;
      default: return $urandom_range(1, span - 1);
    endcase
  endfunction

  task automatic drain_wait();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    send_eval(22'h000100, 0);
    send_beat(MODE_NONE, '1, '1, '1, '1, '1, '1, '1, 1);
    send_beat(MODE_APPEND, 32'sh7FFFFFFF, 32'sh80000000, 0, 18'sh1FFFF, 18'sh20000, 0, 0, 0);
    send_eval(22'h000000, 1);
    send_eval(22'h3FFFFF, 1);
    send_beat(MODE_APPEND, 32'sh80000000, 32'sh7FFFFFFF, 32'sh00010000,
              18'sh20000, 18'sh1FFFF, 18'sh10000, 0, 0);
    send_eval(22'h008000, 0);
    send_eval(22'h00FFFF, 1);
    send_eval(22'h000001, 0);
    send_eval(22'h010000, 0);
    send_beat(MODE_APPEND, 32'sh00030000, 32'shFFFE0000, 32'sh00005000, 0, 0, 0, 0, 0);
    send_beat(MODE_APPEND, 32'sh00040000, 32'sh00020000, 32'shFFFF0000, 18'sh10000, 0, 0, 0, 0);
    send_eval(22'h018000, 0);
    send_eval(22'h018000, 1);
    send_eval(22'h028000, 1);
    send_beat(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    send_eval(22'h010000, 0);
  endtask

  task automatic test_table_full();
    send_beat(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (MAX_WP + 2) send_append();
    repeat (6) send_eval(rnd_t(), $urandom);
    send_eval((MAX_WP - 1) << FRAC_BITS, 0);
    send_eval(((MAX_WP - 1) << FRAC_BITS) - 1, 1);
  endtask

  task automatic test_backpressure();
    rx_hold_req = 1;
    for (int k = 0; k < 12; k++) send_beat(MODE_EVAL, 0, 0, 0, 0, 0, 0, rnd_t(), k[0], 0);
    drain_wait();
  endtask

  task automatic test_random();
    int n;
    n = 0;
    while (n < 540) begin
      case ($urandom_range(0, 19))
        0: send_beat(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
        1: send_beat(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
        2, 3, 4, 5: send_append();
        default: send_eval(rnd_t(), $urandom);
      endcase
      n++;
      if (n == 270) drain_wait();
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold_req && !hold_rx) begin
      hold_rx <= 1;
      rx_hold_req = 0;
      out_ready <= 1'b0;
      fork begin
        repeat (200) @(posedge clk);
        hold_rx <= 0;
      end join_none
    end else if (!hold_rx && rst_n)
      out_ready <= ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 19) == 0) : $urandom_range(0, 3) != 0;
  end

  always @(posedge clk) begin
    spline_res_t e;
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        e = pending_q.pop_front();
        if (out_x !== e.x || out_y !== e.y || out_z !== e.z ||
            out_status !== e.st || out_waypoint_count !== e.cnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h st%0d n%0d got %h %h %h st%0d n%0d",
                     e.x, e.y, e.z, e.st, e.cnt, out_x, out_y, out_z,
                     out_status, out_waypoint_count);
        end
      end
    end
    if (cycles > 400000) begin
      $display("** catmull_rom_waypoint_interpolator: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_backpressure();
    test_random();
    drain_wait();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("** catmull_rom_waypoint_interpolator: PASSED **");
    else
      $display("** catmull_rom_waypoint_interpolator: FAILED **");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/cri_pkg.sv
design/cri_ram.sv
design/cri_ctrl.sv
design/cri_dp.sv
design/catmull_rom_waypoint_interpolator.sv
design/cri_chk.sv
verif/tb_catmull_rom_waypoint_interpolator.sv
